/* sv/alag_pkg.sv */
// shared widths, register indexes, reset values and limits of the audio level block
// no dependencies; imported by every module of the block
package alag_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int RAW_W      = 12;
    localparam int LEVEL_W    = 11;
    localparam int THR_W      = 10;
    localparam int SENS_W     = 4;
    localparam int MINMAX_W   = 14;
    localparam int PROD_W     = RAW_W + SENS_W;

    localparam int WINDOW_DEF = 10;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W  = 16;
    localparam int M_FIELDS_W = LEVEL_W + RAW_W + RAW_W + THR_W;
    localparam int M_TDATA_W  = 48;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_DC_OFFSET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_EN    = 3'd4;

    // reset values
    localparam logic [SAMPLE_W-1:0]        DC_OFFSET_RST = 12'd2048;
    localparam logic [SENS_W-1:0]          SENS_RST      = 4'd5;
    localparam logic [THR_W-1:0]           THR_RST       = 10'd100;
    localparam logic signed [MINMAX_W-1:0] MIN_RST       = 14'sd4095;
    localparam logic signed [MINMAX_W-1:0] MAX_RST       = 14'sd0;

    // gain adaptation and scaling constants
    localparam int RANGE_MIN   = 50;
    localparam int THR_LO      = 50;
    localparam int THR_HI      = 500;
    localparam int TRACK_STEP  = 10;
    localparam int SCALE_MUL   = 100;
    localparam int SCALE_SHIFT = 11;

    typedef struct packed {
        logic             push;
        logic             tick;
        logic             auto_en;
        logic             load;
        logic [THR_W-1:0] load_value;
    } gain_ctrl_t;

endpackage

/* sv/audio_level_auto_gain_top.sv */
// audio level meter with automatic threshold adaptation, top level
// depends on alag_pkg, alag_ring and alag_gain
//
// Takes one microphone sample per request and, while audio is enabled, returns one result
// (scaled level, raw level, mean of the last WINDOW raw levels, current threshold); with
// audio disabled a request is taken and dropped without touching any state. One request is
// accepted every clock cycle unless the output side stalls; a result leaves through an input
// register, a register holding the updated state, and the output register. All state
// (level ring, running sum, min/max, threshold) updates as a request leaves the input
// register, so consecutive requests see each other's effect. Configuration writes take
// effect at once and are meant for an idle block; writing the threshold setting also
// loads the live threshold.
module audio_level_auto_gain_top
    import alag_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,    // [11:0] sample
    input  logic                  s_tuser,    // [0] gain_tick

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,    // [10:0] level, [22:11] raw_level,
                                              // [34:23] average_level, [44:35] threshold

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int SUM_W       = RAW_W + $clog2(WINDOW);
    // divide by WINDOW as multiply by a rounded-up reciprocal, exact for any SUM_W-bit sum
    localparam int SHIFT       = SUM_W + $clog2(WINDOW);
    localparam int RECIP_W     = SUM_W + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2**SHIFT + WINDOW - 1) / WINDOW);
    localparam int AVG_PROD_W  = SUM_W + RECIP_W;
    localparam int SCALE_PROD_W = PROD_W + 7;

    // configuration registers
    logic [SAMPLE_W-1:0] dc_offset_reg;
    logic [SENS_W-1:0]   sens_reg;
    logic                auto_gain_reg;
    logic                audio_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dc_offset_reg <= DC_OFFSET_RST;
            sens_reg      <= SENS_RST;
            auto_gain_reg <= 1'b0;
            audio_en_reg  <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_DC_OFFSET:   dc_offset_reg <= cfg_wdata[SAMPLE_W-1:0];
                CFG_SENSITIVITY: sens_reg      <= cfg_wdata[SENS_W-1:0];
                CFG_AUTO_GAIN:   auto_gain_reg <= cfg_wdata[0];
                CFG_AUDIO_EN:    audio_en_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // pipeline occupancy and flow control
    logic in_valid_reg;
    logic mid_valid_reg;
    logic out_valid_reg;
    logic out_ready;
    logic mid_ready;
    logic in_ready;
    logic push;

    assign out_ready = !out_valid_reg || m_tready;
    assign mid_ready = !mid_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || mid_ready;
    assign push      = in_valid_reg && mid_ready && audio_en_reg;

    assign s_tready  = in_ready;
    assign m_tvalid  = out_valid_reg;

    // input register
    logic [SAMPLE_W-1:0] sample_reg;
    logic                tick_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && s_tvalid) begin
            sample_reg <= s_tdata[SAMPLE_W-1:0];
            tick_reg   <= s_tuser;
        end
    end

    // raw level and state update
    logic [RAW_W-1:0]  raw;
    logic [SUM_W-1:0]  sum_next;
    logic [THR_W-1:0]  thr_next;
    logic [PROD_W-1:0] sens_prod;
    gain_ctrl_t        gain_ctrl;

    assign raw = (sample_reg >= dc_offset_reg) ? sample_reg - dc_offset_reg
                                               : dc_offset_reg - sample_reg;
    assign sens_prod = PROD_W'(raw) * PROD_W'(sens_reg);

    always_comb begin
        gain_ctrl.push       = push;
        gain_ctrl.tick       = tick_reg;
        gain_ctrl.auto_en    = auto_gain_reg;
        gain_ctrl.load       = cfg_wr_en && (cfg_addr == CFG_THRESHOLD);
        gain_ctrl.load_value = cfg_wdata[THR_W-1:0];
    end

    alag_ring #(
        .WINDOW   (WINDOW)
    ) u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .raw      (raw),
        .sum_next (sum_next)
    );

    alag_gain u_gain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (gain_ctrl),
        .raw      (raw),
        .thr_next (thr_next)
    );

    // middle register
    logic [RAW_W-1:0]  raw_mid_reg;
    logic [SUM_W-1:0]  sum_mid_reg;
    logic [PROD_W-1:0] prod_mid_reg;
    logic [THR_W-1:0]  thr_mid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
        end else if (mid_ready) begin
            mid_valid_reg <= in_valid_reg && audio_en_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            raw_mid_reg  <= raw;
            sum_mid_reg  <= sum_next;
            prod_mid_reg <= sens_prod;
            thr_mid_reg  <= thr_next;
        end
    end

    // mean and scaled level
    logic [AVG_PROD_W-1:0]   avg_prod;
    logic [RAW_W-1:0]        avg;
    logic [SCALE_PROD_W-1:0] scale_prod;
    logic [RAW_W-1:0]        scaled;
    logic [LEVEL_W-1:0]      limit;
    logic [LEVEL_W-1:0]      level;

    assign avg_prod   = AVG_PROD_W'(sum_mid_reg) * AVG_PROD_W'(RECIP);
    assign avg        = avg_prod[SHIFT +: RAW_W];
    assign scale_prod = SCALE_PROD_W'(prod_mid_reg) * SCALE_PROD_W'(SCALE_MUL);
    assign scaled     = scale_prod[SCALE_SHIFT +: RAW_W];
    assign limit      = {thr_mid_reg, 1'b0};
    assign level      = (scaled > RAW_W'(limit)) ? limit : scaled[LEVEL_W-1:0];

    // output register
    logic [M_TDATA_W-1:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && mid_valid_reg) begin
            out_data_reg <= {{M_PAD_W{1'b0}}, thr_mid_reg, avg, raw_mid_reg, level};
        end
    end

    assign m_tdata = out_data_reg;

endmodule

/* sv/alag_ring.sv */
// ring of recent raw levels with a running sum of its entries
// depends on alag_pkg
module alag_ring
    import alag_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                push,
    input  logic [RAW_W-1:0]                    raw,
    output logic [RAW_W+$clog2(WINDOW)-1:0]     sum_next
);

    localparam int IDX_W = $clog2(WINDOW);
    localparam int SUM_W = RAW_W + IDX_W;

    logic [RAW_W-1:0] ring_reg [WINDOW];
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [SUM_W-1:0] sum_reg;

    // the entry being overwritten leaves the sum, the new level joins it
    assign sum_next = sum_reg - SUM_W'(ring_reg[idx_reg]) + SUM_W'(raw);
    assign idx_next = (idx_reg == IDX_W'(WINDOW - 1)) ? '0 : idx_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) begin
                ring_reg[i] <= '0;
            end
            idx_reg <= '0;
            sum_reg <= '0;
        end else if (push) begin
            ring_reg[idx_reg] <= raw;
            idx_reg           <= idx_next;
            sum_reg           <= sum_next;
        end
    end

endmodule

/* sv/alag_gain.sv */
// min/max level tracking and threshold adaptation on the gain tick
// depends on alag_pkg
module alag_gain
    import alag_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  gain_ctrl_t       ctrl,
    input  logic [RAW_W-1:0] raw,
    output logic [THR_W-1:0] thr_next
);

    logic signed [MINMAX_W-1:0] min_reg;
    logic signed [MINMAX_W-1:0] max_reg;
    logic signed [MINMAX_W-1:0] min_next;
    logic signed [MINMAX_W-1:0] max_next;
    logic signed [MINMAX_W-1:0] raw_s;
    logic signed [MINMAX_W-1:0] min_trk;
    logic signed [MINMAX_W-1:0] max_trk;
    logic signed [MINMAX_W:0]   range_w;
    logic signed [MINMAX_W:0]   thr_cand;
    logic [THR_W-1:0]           thr_reg;
    logic [THR_W-1:0]           thr_clamp;
    logic                       adapt;

    always_comb begin
        raw_s    = signed'({{(MINMAX_W-RAW_W){1'b0}}, raw});
        min_trk  = (raw_s < min_reg) ? raw_s : min_reg;
        max_trk  = (raw_s > max_reg) ? raw_s : max_reg;
        range_w  = (MINMAX_W+1)'(max_trk) - (MINMAX_W+1)'(min_trk);
        thr_cand = (MINMAX_W+1)'(min_trk) + (range_w >>> 1);
        adapt    = ctrl.tick && (range_w > RANGE_MIN);

        if (thr_cand < THR_LO) begin
            thr_clamp = THR_W'(THR_LO);
        end else if (thr_cand > THR_HI) begin
            thr_clamp = THR_W'(THR_HI);
        end else begin
            thr_clamp = thr_cand[THR_W-1:0];
        end

        min_next = min_reg;
        max_next = max_reg;
        thr_next = thr_reg;
        if (ctrl.auto_en) begin
            min_next = min_trk;
            max_next = max_trk;
            if (adapt) begin
                // pull the tracked range in so it follows a falling level
                min_next = min_trk + MINMAX_W'(TRACK_STEP);
                max_next = max_trk - MINMAX_W'(TRACK_STEP);
                thr_next = thr_clamp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= MIN_RST;
            max_reg <= MAX_RST;
            thr_reg <= THR_RST;
        end else if (ctrl.load) begin
            thr_reg <= ctrl.load_value;
        end else if (ctrl.push) begin
            min_reg <= min_next;
            max_reg <= max_next;
            thr_reg <= thr_next;
        end
    end

endmodule

/* sv/alag_checker.sv */
// port-level checks on the audio level block, attached to the top level by bind
// depends on alag_pkg and audio_level_auto_gain_top
module alag_checker
    import alag_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [LEVEL_W-1:0] out_level;
    logic [RAW_W-1:0]   out_raw;
    logic [THR_W-1:0]   out_thr;

    assign out_level = m_tdata[LEVEL_W-1:0];
    assign out_raw   = m_tdata[LEVEL_W +: RAW_W];
    assign out_thr   = m_tdata[LEVEL_W + 2*RAW_W +: THR_W];

    // pipeline comes out of reset empty and ready
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("pipeline not empty after reset");

    // gain of at most fifteen hundred over two thousand and forty-eight never exceeds unity
    a_level_le_raw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, out_level} <= out_raw))
        else $error("scaled level above raw level");

    a_level_le_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_level <= {out_thr, 1'b0}))
        else $error("scaled level above twice the threshold");

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind audio_level_auto_gain_top alag_checker u_alag_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/audio_level_auto_gain_top_tb.sv */
`timescale 1ns / 100ps
// self-checking bench for audio_level_auto_gain_top: directed and random sample requests,
// register settings between phases, and a level/threshold predictor kept in the bench
// depends on alag_pkg and the rtl of the block
module audio_level_auto_gain_top_tb;
    import alag_pkg::*;

    localparam int RING_DEPTH    = 10;
    localparam int SCALE_NUM     = 100;
    localparam int SCALE_DEN     = 2048;
    localparam int SPREAD_MIN    = 50;
    localparam int THR_FLOOR     = 50;
    localparam int THR_CEIL      = 500;
    localparam int MINMAX_STEP   = 10;
    localparam int MAX_GAP       = 5;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 150;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 830;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [RAW_W-1:0]   raw_level;
        logic [RAW_W-1:0]   average_level;
        logic [THR_W-1:0]   threshold;
    } level_result_t;

    class level_meter_checker;
        logic [SAMPLE_W-1:0] dc_offset;
        logic [SENS_W-1:0]   sensitivity;
        logic                auto_gain;
        logic                audio_on;
        logic [RAW_W-1:0]    history [RING_DEPTH];
        int                  history_pos;
        int                  min_level;
        int                  max_level;
        logic [THR_W-1:0]    threshold_now;
        level_result_t       pending_levels [$];
        int                  mismatches;

        function new();
            dc_offset     = 12'd2048;
            sensitivity   = 4'd5;
            auto_gain     = 1'b0;
            audio_on      = 1'b1;
            foreach (history[i]) history[i] = '0;
            history_pos   = 0;
            min_level     = 4095;
            max_level     = 0;
            threshold_now = 10'd100;
            mismatches    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DC_OFFSET:   dc_offset = val[SAMPLE_W-1:0];
                CFG_SENSITIVITY: sensitivity = val[SENS_W-1:0];
                CFG_THRESHOLD:   threshold_now = val[THR_W-1:0];
                CFG_AUTO_GAIN:   auto_gain = val[0];
                CFG_AUDIO_EN:    audio_on = val[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_levels.size();
        endfunction

        // one accepted sample request
        function void take_sample(logic [SAMPLE_W-1:0] smp, logic tick);
            int raw;
            int spread;
            int target;
            int total;
            int scaled;
            int limit;
            level_result_t res;
            if (!audio_on) return;
            raw = (smp >= dc_offset) ? int'(smp) - int'(dc_offset)
                                     : int'(dc_offset) - int'(smp);
            if (auto_gain) begin
                if (raw < min_level) min_level = raw;
                if (raw > max_level) max_level = raw;
                spread = max_level - min_level;
                if (tick && spread > SPREAD_MIN) begin
                    target = min_level + spread / 2;
                    min_level += MINMAX_STEP;
                    max_level -= MINMAX_STEP;
                    if (target < THR_FLOOR) target = THR_FLOOR;
                    if (target > THR_CEIL) target = THR_CEIL;
                    threshold_now = THR_W'(target);
                end
            end
            history[history_pos] = RAW_W'(raw);
            history_pos = (history_pos + 1) % RING_DEPTH;
            total = 0;
            foreach (history[i]) total += int'(history[i]);
            // clamp against the threshold as just adapted
            scaled = raw * int'(sensitivity) * SCALE_NUM / SCALE_DEN;
            limit  = 2 * int'(threshold_now);
            if (scaled > limit) scaled = limit;
            res.level         = LEVEL_W'(scaled);
            res.raw_level     = RAW_W'(raw);
            res.average_level = RAW_W'(total / RING_DEPTH);
            res.threshold     = threshold_now;
            pending_levels.push_back(res);
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_level(logic [M_TDATA_W-1:0] data);
            level_result_t got;
            level_result_t want;
            got.level         = data[10:0];
            got.raw_level     = data[22:11];
            got.average_level = data[34:23];
            got.threshold     = data[44:35];
            if (pending_levels.size() == 0) begin
                report($sformatf("result %h with no request outstanding", data));
                return;
            end
            want = pending_levels.pop_front();
            if (got.level != want.level)
                report($sformatf("level %0d, want %0d", got.level, want.level));
            if (got.raw_level != want.raw_level)
                report($sformatf("raw_level %0d, want %0d", got.raw_level, want.raw_level));
            if (got.average_level != want.average_level)
                report($sformatf("average_level %0d, want %0d",
                                 got.average_level, want.average_level));
            if (got.threshold != want.threshold)
                report($sformatf("threshold %0d, want %0d", got.threshold, want.threshold));
        endtask
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    bit tx_calm  = 1'b0;
    bit rx_calm  = 1'b0;
    bit hold_req = 1'b0;
    int stall_count = 0;

    level_meter_checker meter;

    audio_level_auto_gain_top #(
        .WINDOW(RING_DEPTH)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) meter.check_level(m_tdata);
            if (s_tvalid && s_tready) meter.take_sample(s_tdata[SAMPLE_W-1:0], s_tuser);
        end
    end

    // result side: random wait after each result, or one long hold when asked
    initial begin : result_sink
        int gap;
        int hold;
        gap  = 0;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) gap = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_req) begin
                hold     = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    task automatic send_sample(logic [SAMPLE_W-1:0] smp, logic tick);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(smp);
        s_tuser  <= tick;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop offering and wait out every outstanding result, plus requests that give none
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (meter.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        meter.write_reg(idx, val);
    endtask

    task automatic configure(logic [SAMPLE_W-1:0] dc, logic [SENS_W-1:0] sens,
                             logic [THR_W-1:0] thr, logic load_thr, logic agc, logic audio);
        drain_results();
        put_reg(CFG_DC_OFFSET, CFG_DATA_W'(dc));
        put_reg(CFG_SENSITIVITY, CFG_DATA_W'(sens));
        if (load_thr) put_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
        put_reg(CFG_AUTO_GAIN, CFG_DATA_W'(agc));
        put_reg(CFG_AUDIO_EN, CFG_DATA_W'(audio));
        // unmapped index, must be ignored
        if ($urandom_range(0, 3) == 0)
            put_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                    CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] centre,
                                                        int swing, bit loud);
        if (loud) begin
            case ($urandom_range(0, 7))
                0: return '0;
                1: return '1;
                2: return SAMPLE_W'($urandom);
                default: ;
            endcase
        end
        return centre + SAMPLE_W'($urandom_range(0, 2 * swing)) - SAMPLE_W'(swing);
    endfunction

    initial begin
        int phase_no;
        int phase_len;
        int sent;
        int swing;
        int tick_pct;
        bit loud;
        bit late;
        bit audio;
        logic [SAMPLE_W-1:0] dc;
        logic [THR_W-1:0] thr;

        meter = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings, auto gain off so ticks are ignored
        send_sample(12'd0, 1'b1);
        send_sample(12'd4095, 1'b0);
        send_sample(12'd2048, 1'b1);
        send_sample(12'd2047, 1'b0);
        send_sample(12'd2049, 1'b1);

        // top sensitivity, threshold beyond one thousand, clamp hit
        configure(12'd0, 4'd15, 10'd1023, 1'b1, 1'b0, 1'b1);
        send_sample(12'd4095, 1'b1);
        send_sample(12'd4095, 1'b0);
        send_sample(12'd0, 1'b0);

        // zero sensitivity and threshold, tracking starts from the reset min/max
        configure(12'd4095, 4'd0, 10'd0, 1'b1, 1'b1, 1'b1);
        send_sample(12'd0, 1'b1);
        send_sample(12'd4095, 1'b1);

        // wide range tick, threshold clamped to the ceiling
        configure(12'd2048, 4'd10, 10'd100, 1'b1, 1'b1, 1'b1);
        send_sample(12'd2148, 1'b0);
        send_sample(12'd1948, 1'b1);

        // auto gain off: tick ignored, min/max held
        configure(12'd2048, 4'd10, 10'd60, 1'b1, 1'b0, 1'b1);
        send_sample(12'd3048, 1'b1);

        // audio off: requests taken, nothing changes
        configure(12'd2048, 4'd10, 10'd60, 1'b0, 1'b1, 1'b0);
        send_sample(12'd100, 1'b1);
        send_sample(12'd4000, 1'b0);
        send_sample(12'd2048, 1'b1);

        // audio back on with held min/max, ticks over a wide range
        configure(12'd1, 4'd7, 10'd1000, 1'b1, 1'b1, 1'b1);
        send_sample(12'd4095, 1'b1);
        send_sample(12'd0, 1'b1);
        send_sample(12'd1, 1'b0);
        send_sample(12'd2, 1'b1);

        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS) begin
            // later phases stay quiet with frequent ticks so min/max close in
            late  = (sent > RANDOM_ITEMS / 2);
            audio = (phase_no < 3) || ($urandom_range(0, 5) != 0);
            if (late) begin
                dc = SAMPLE_W'(1024 + $urandom_range(0, 2047));
            end else begin
                case ($urandom_range(0, 3))
                    0: dc = '0;
                    1: dc = '1;
                    2: dc = 12'd2048;
                    default: dc = SAMPLE_W'($urandom);
                endcase
            end
            case ($urandom_range(0, 3))
                0: thr = '0;
                1: thr = '1;
                default: thr = THR_W'($urandom_range(0, 1023));
            endcase
            loud     = !late && ($urandom_range(0, 2) == 0);
            swing    = late ? $urandom_range(5, 150) : $urandom_range(5, 2047);
            tick_pct = late ? 75 : 16;
            tx_calm  = ($urandom_range(0, 3) == 0);
            rx_calm  = ($urandom_range(0, 3) == 0);
            configure(dc, SENS_W'($urandom_range(0, 15)), thr, 1'($urandom_range(0, 1)),
                      late ? ($urandom_range(0, 7) != 0) : 1'($urandom_range(0, 1)), audio);
            phase_len = audio ? $urandom_range(30, 120) : 15;
            for (int k = 0; k < phase_len; k++) begin
                // result side holds off while requests keep coming
                if (phase_no == 0 && k == 10) begin
                    tx_calm  = 1'b1;
                    hold_req = 1'b1;
                end
                if (phase_no == 1 && k == phase_len / 2) drain_results();
                send_sample(pick_sample(dc, swing, loud), $urandom_range(0, 99) < tick_pct);
            end
            if (audio) sent += phase_len;
            phase_no++;
        end

        drain_results();
        if (meter.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
